// ===== hw/rtl/glnw_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and constants for the Gauss-Legendre node/weight unit.
// Used by the controller, datapath, divider and top level; no dependencies.
package glnw_pkg;

	localparam int MAX_POINTS   = 64;
	localparam int FRAC_BITS    = 30;
	localparam int NEWTON_LIMIT = 50;
	localparam int CORDIC_STEPS = 30;

	localparam int IDX_W      = 6;
	localparam int PC_W       = 7;
	localparam int TOL_W      = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam int X_W        = 32;
	localparam int W_W        = 32;
	localparam int ST_W       = 2;
	localparam int C_W        = 33;  // CORDIC x, y, angle
	localparam int P_W        = 36;  // Legendre values
	localparam int D_W        = 33;  // 1 - x^2
	localparam int A_W        = 39;  // P_n * (1 - x^2)
	localparam int NUM_W      = 44;  // short dividend
	localparam int DEN_W      = 44;  // divisor
	localparam int Q_W        = 63;  // long quotient incl. cap value
	localparam int QUO_W      = 62;  // quotient bits shifted out of divider
	localparam int REM_W      = 45;
	localparam int STEP_CNT_W = 5;
	localparam int JCNT_W     = 6;
	localparam int CI_W       = 5;

	localparam int SHORT_STEPS = NUM_W / 2;
	localparam int LONG_STEPS  = QUO_W / 2;

	localparam logic [31:0] PI_Q30   = 32'd3373259426;
	localparam logic [29:0] GAIN_Q30 = 30'd652032874;

	localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 1'b1;

	localparam logic [ST_W-1:0] STATUS_CONVERGED = 2'd0;
	localparam logic [ST_W-1:0] STATUS_LIMIT     = 2'd1;
	localparam logic [ST_W-1:0] STATUS_RANGE     = 2'd2;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_RANGE_ERR,
		OP_SINGLE,
		OP_THETA,
		OP_CORDIC_INIT,
		OP_CORDIC_ITER,
		OP_CORDIC_END,
		OP_NEWTON_D,
		OP_LEG_INIT,
		OP_LEG_MUL,
		OP_LEG_NUM,
		OP_LEG_UPDATE,
		OP_NEWTON_A,
		OP_NEWTON_B,
		OP_NEWTON_DEN,
		OP_NEWTON_DIV,
		OP_NEWTON_STEP,
		OP_NEWTON_UPDATE,
		OP_SET_LIMIT,
		OP_WEIGHT_D,
		OP_WEIGHT_Q,
		OP_WEIGHT_DIV1,
		OP_WEIGHT_DIV2,
		OP_WEIGHT_END
	} dp_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SETUP,
		ST_THETA_WAIT,
		ST_CORDIC,
		ST_CORDIC_END,
		ST_NEWTON_D,
		ST_NEWTON_CHK,
		ST_LEG_MUL,
		ST_LEG_NUM,
		ST_LEG_WAIT,
		ST_NEWTON_A,
		ST_NEWTON_B,
		ST_NEWTON_DEN,
		ST_NEWTON_DIVS,
		ST_NEWTON_WAIT,
		ST_NEWTON_EVAL,
		ST_WEIGHT_D,
		ST_WEIGHT_LEG,
		ST_WEIGHT_Q,
		ST_WEIGHT_DIV1,
		ST_WEIGHT_WAIT1,
		ST_WEIGHT_WAIT2,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic out_of_range;
		logic single;
		logic div_done;
		logic cordic_last;
		logic leg_last;
		logic d_nonpos;
		logic den_zero;
		logic step_small;
		logic step_limit;
	} dp_status_t;

	typedef struct packed {
		dp_op_t op;
		logic   out_load;
	} ctrl_cmd_t;

	function automatic logic [29:0] atan_q30(input logic [CI_W-1:0] k);
		logic [29:0] v;
		unique case (k)
			5'd0:    v = 30'd843314857;
			5'd1:    v = 30'd497837829;
			5'd2:    v = 30'd263043837;
			5'd3:    v = 30'd133525159;
			5'd4:    v = 30'd67021687;
			5'd5:    v = 30'd33543516;
			5'd6:    v = 30'd16775851;
			5'd7:    v = 30'd8388437;
			5'd8:    v = 30'd4194283;
			5'd9:    v = 30'd2097149;
			5'd10:   v = 30'd1048576;
			5'd11:   v = 30'd524288;
			5'd12:   v = 30'd262144;
			5'd13:   v = 30'd131072;
			5'd14:   v = 30'd65536;
			5'd15:   v = 30'd32768;
			5'd16:   v = 30'd16384;
			5'd17:   v = 30'd8192;
			5'd18:   v = 30'd4096;
			5'd19:   v = 30'd2048;
			5'd20:   v = 30'd1024;
			5'd21:   v = 30'd512;
			5'd22:   v = 30'd256;
			5'd23:   v = 30'd128;
			5'd24:   v = 30'd64;
			5'd25:   v = 30'd32;
			5'd26:   v = 30'd16;
			5'd27:   v = 30'd8;
			5'd28:   v = 30'd4;
			5'd29:   v = 30'd2;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== hw/rtl/glnw_div.sv =====
`timescale 1ns / 1ps
// Restoring unsigned divider, two quotient bits per cycle.
// Depends on glnw_pkg for widths.
module glnw_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [glnw_pkg::REM_W-1:0]        rem_init,
	input  logic [glnw_pkg::QUO_W-1:0]        dividend,
	input  logic [glnw_pkg::STEP_CNT_W-1:0]   steps,
	input  logic [glnw_pkg::DEN_W-1:0]        divisor,
	output logic                              done,
	output logic [glnw_pkg::QUO_W-1:0]        quotient
);
	import glnw_pkg::*;

	logic                  busy_q, done_q;
	logic [REM_W-1:0]      rem_q;
	logic [QUO_W-1:0]      bits_q, quo_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0]      div_q;
	logic [REM_W-1:0]      r1w, r1, r2w, r2;
	logic                  b1, b2;

	always_comb begin
		r1w = {rem_q[REM_W-2:0], bits_q[QUO_W-1]};
		b1  = r1w >= {1'b0, div_q};
		r1  = b1 ? r1w - {1'b0, div_q} : r1w;
		r2w = {r1[REM_W-2:0], bits_q[QUO_W-2]};
		b2  = r2w >= {1'b0, div_q};
		r2  = b2 ? r2w - {1'b0, div_q} : r2w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == STEP_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= rem_init;
			bits_q <= dividend;
			quo_q  <= '0;
			cnt_q  <= steps;
			div_q  <= divisor;
		end else if (busy_q) begin
			rem_q  <= r2;
			bits_q <= {bits_q[QUO_W-3:0], 2'b00};
			quo_q  <= {quo_q[QUO_W-3:0], b1, b2};
			cnt_q  <= cnt_q - STEP_CNT_W'(1);
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// ===== hw/rtl/glnw_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: config registers, CORDIC, Legendre recurrence, Newton update, weight.
// Depends on glnw_pkg and glnw_div; glnw_ctrl drives at most one op per cycle.
module glnw_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [glnw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [glnw_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [glnw_pkg::IDX_W-1:0]        node_index,
	input  glnw_pkg::dp_op_t                  op,
	output glnw_pkg::dp_status_t              stat,
	output logic signed [glnw_pkg::X_W-1:0]   node_value,
	output logic [glnw_pkg::W_W-1:0]          weight_value,
	output logic [glnw_pkg::ST_W-1:0]         status
);
	import glnw_pkg::*;

	localparam logic signed [63:0] ONE64 = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [67:0] RND68 = 68'sd1 <<< (FRAC_BITS - 1);

	logic [PC_W-1:0]  pc_q;
	logic [TOL_W-1:0] tol_q;

	logic [IDX_W-1:0]        idx_q;
	logic                    flip_q, neg_q, cap_q, rec_neg_q;
	logic signed [X_W-1:0]   x_q;
	logic signed [C_W-1:0]   cx_q, cy_q, z_q;
	logic [CI_W-1:0]         ci_q;
	logic signed [P_W-1:0]   p0_q, p1_q, t_q;
	logic [PC_W-1:0]         k_q;
	logic signed [D_W-1:0]   d_q;
	logic signed [A_W-1:0]   a_q;
	logic signed [DEN_W-1:0] den_q;
	logic [Q_W-1:0]          mag_q;
	logic [JCNT_W-1:0]       j_q;
	logic [W_W-1:0]          w_q;
	logic [ST_W-1:0]         st_q;

	logic [PC_W-1:0]         n_eff;
	logic [7:0]              tnum0, tnum, coef_a;
	logic [8:0]              tden;
	logic                    flip_n;
	logic [NUM_W-1:0]        theta_num;
	logic signed [67:0]      prod_xp, rnd_xp;
	logic signed [63:0]      prod_xx, rnd_xx;
	logic signed [67:0]      prod_pd, rnd_pd;
	logic signed [D_W-1:0]   d_next;
	logic signed [P_W:0]     diff;
	logic signed [DEN_W-1:0] den_next, nq;
	logic [PC_W-1:0]         coef_b;
	logic signed [NUM_W-1:0] rec_num, rec_p2;
	logic [NUM_W-1:0]        rec_abs, rec_div_num;
	logic [A_W-1:0]          a_abs;
	logic [DEN_W-1:0]        den_abs;
	logic [Q_W-1:0]          long_a, udiv_res;
	logic [DEN_W-1:0]        long_b;
	logic signed [63:0]      xw;
	logic signed [C_W-1:0]   dx, dy, atan_s;

	logic                    div_start, div_done;
	logic [REM_W-1:0]        div_rem;
	logic [QUO_W-1:0]        div_bits, quo;
	logic [STEP_CNT_W-1:0]   div_steps;
	logic [DEN_W-1:0]        div_den;

	assign n_eff = (pc_q > PC_W'(MAX_POINTS)) ? PC_W'(MAX_POINTS) : pc_q;

	// Starting angle pi*(4i+3)/(4n+2), folded into the first quadrant.
	always_comb begin
		tnum0     = {idx_q, 2'b11};
		tden      = {n_eff, 2'b10};
		flip_n    = {1'b0, tnum0} > {n_eff, 1'b1};
		tnum      = flip_n ? 8'(tden - {1'b0, tnum0}) : tnum0;
		theta_num = NUM_W'(PI_Q30) * NUM_W'(tnum) + NUM_W'(tden >> 1);
	end

	always_comb begin
		prod_xp = x_q * p1_q;
		rnd_xp  = (prod_xp + RND68) >>> FRAC_BITS;
		prod_xx = x_q * x_q;
		rnd_xx  = (prod_xx + 64'(RND68)) >>> FRAC_BITS;
		d_next  = D_W'(ONE64) - rnd_xx[D_W-1:0];
		prod_pd = p1_q * d_q;
		rnd_pd  = (prod_pd + RND68) >>> FRAC_BITS;
		diff    = (P_W+1)'(p0_q) - (P_W+1)'(t_q);
		den_next = DEN_W'(diff) * DEN_W'($signed({1'b0, n_eff}));
		nq       = DEN_W'(p0_q) * DEN_W'($signed({1'b0, n_eff}));
	end

	// Three-term recurrence numerator, rounded to nearest on division by k.
	always_comb begin
		coef_a      = {k_q, 1'b0} - 8'd1;
		coef_b      = k_q - PC_W'(1);
		rec_num     = NUM_W'(t_q) * NUM_W'($signed({1'b0, coef_a}))
			- NUM_W'(p0_q) * NUM_W'($signed({1'b0, coef_b}));
		rec_abs     = rec_num[NUM_W-1] ? NUM_W'(-rec_num) : NUM_W'(rec_num);
		rec_div_num = rec_abs + NUM_W'(k_q >> 1);
		rec_p2      = rec_neg_q ? -$signed(quo[NUM_W-1:0]) : $signed(quo[NUM_W-1:0]);
	end

	always_comb begin
		a_abs    = a_q[A_W-1] ? A_W'(-a_q) : A_W'(a_q);
		den_abs  = den_q[DEN_W-1] ? DEN_W'(-den_q) : DEN_W'(den_q);
		udiv_res = cap_q ? (Q_W'(1) << (Q_W - 1)) : {1'b0, quo};
	end

	// Divider operand select.
	always_comb begin
		div_start = 1'b0;
		long_a    = '0;
		long_b    = den_abs;
		div_rem   = '0;
		div_bits  = '0;
		div_steps = STEP_CNT_W'(SHORT_STEPS);
		div_den   = '0;
		unique case (op)
			OP_THETA: begin
				div_start = 1'b1;
				div_bits  = {theta_num, {(QUO_W-NUM_W){1'b0}}};
				div_den   = DEN_W'(tden);
			end
			OP_LEG_NUM: begin
				div_start = 1'b1;
				div_bits  = {rec_div_num, {(QUO_W-NUM_W){1'b0}}};
				div_den   = DEN_W'(k_q);
			end
			OP_NEWTON_DIV: begin
				div_start = 1'b1;
				long_a    = Q_W'(a_abs);
			end
			OP_WEIGHT_DIV1: begin
				div_start = 1'b1;
				long_a    = Q_W'({d_q, 1'b0});
			end
			OP_WEIGHT_DIV2: begin
				div_start = 1'b1;
				long_a    = udiv_res;
			end
			default: ;
		endcase
		if (op == OP_NEWTON_DIV || op == OP_WEIGHT_DIV1 || op == OP_WEIGHT_DIV2) begin
			div_rem   = REM_W'(long_a[Q_W-1:32]);
			div_bits  = {long_a[31:0], {(QUO_W-32){1'b0}}};
			div_steps = STEP_CNT_W'(LONG_STEPS);
			div_den   = long_b;
		end
	end

	glnw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (div_rem),
		.dividend (div_bits),
		.steps    (div_steps),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (quo)
	);

	always_comb begin
		dx     = cy_q >>> ci_q;
		dy     = cx_q >>> ci_q;
		atan_s = $signed({3'b000, atan_q30(ci_q)});
		xw     = neg_q ? 64'(x_q) + $signed({1'b0, mag_q})
			: 64'(x_q) - $signed({1'b0, mag_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= PC_W'(8);
			tol_q <= TOL_W'(1);
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_POINT_COUNT: pc_q  <= cfg_data[PC_W-1:0];
				CFG_TOLERANCE:   tol_q <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: begin
				idx_q <= node_index;
				x_q   <= '0;
				w_q   <= '0;
				st_q  <= STATUS_CONVERGED;
				j_q   <= '0;
			end
			OP_RANGE_ERR: st_q <= STATUS_RANGE;
			OP_SINGLE:    w_q  <= W_W'(1) << (FRAC_BITS + 1);
			OP_THETA:     flip_q <= flip_n;
			OP_CORDIC_INIT: begin
				cx_q <= $signed({3'b000, GAIN_Q30});
				cy_q <= '0;
				z_q  <= $signed(quo[C_W-1:0]);
				ci_q <= '0;
			end
			OP_CORDIC_ITER: begin
				if (!z_q[C_W-1]) begin
					cx_q <= cx_q - dx;
					cy_q <= cy_q + dy;
					z_q  <= z_q - atan_s;
				end else begin
					cx_q <= cx_q + dx;
					cy_q <= cy_q - dy;
					z_q  <= z_q + atan_s;
				end
				ci_q <= ci_q + CI_W'(1);
			end
			OP_CORDIC_END: x_q <= flip_q ? X_W'(-cx_q) : X_W'(cx_q);
			OP_NEWTON_D:   d_q <= d_next;
			OP_LEG_INIT: begin
				p0_q <= P_W'(ONE64);
				p1_q <= P_W'(x_q);
				k_q  <= PC_W'(2);
			end
			OP_LEG_MUL: t_q <= rnd_xp[P_W-1:0];
			OP_LEG_NUM: rec_neg_q <= rec_num[NUM_W-1];
			OP_LEG_UPDATE: begin
				p0_q <= p1_q;
				p1_q <= rec_p2[P_W-1:0];
				k_q  <= k_q + PC_W'(1);
			end
			OP_NEWTON_A:    a_q   <= rnd_pd[A_W-1:0];
			OP_NEWTON_B:    t_q   <= rnd_xp[P_W-1:0];
			OP_NEWTON_DEN:  den_q <= den_next;
			OP_NEWTON_DIV:  cap_q <= (long_b == '0) || (DEN_W'(long_a[Q_W-1:32]) >= long_b);
			OP_NEWTON_STEP: begin
				mag_q <= udiv_res;
				neg_q <= a_q[A_W-1] ^ den_q[DEN_W-1];
			end
			OP_NEWTON_UPDATE: begin
				if (xw > ONE64)
					x_q <= X_W'(ONE64);
				else if (xw < -ONE64)
					x_q <= X_W'(-ONE64);
				else
					x_q <= xw[X_W-1:0];
				j_q <= j_q + JCNT_W'(1);
			end
			OP_SET_LIMIT: st_q <= STATUS_LIMIT;
			OP_WEIGHT_D:  d_q  <= d_next[D_W-1] ? '0 : d_next;
			OP_WEIGHT_Q:  den_q <= nq[DEN_W-1] ? -nq : nq;
			OP_WEIGHT_DIV1,
			OP_WEIGHT_DIV2: cap_q <= (long_b == '0) || (DEN_W'(long_a[Q_W-1:32]) >= long_b);
			OP_WEIGHT_END: begin
				if (udiv_res > (Q_W'(1) << (FRAC_BITS + 1)))
					w_q <= W_W'(1) << (FRAC_BITS + 1);
				else
					w_q <= udiv_res[W_W-1:0];
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.out_of_range = {1'b0, idx_q} >= n_eff;
		stat.single       = n_eff == PC_W'(1);
		stat.div_done     = div_done;
		stat.cordic_last  = ci_q == CI_W'(CORDIC_STEPS - 1);
		stat.leg_last     = k_q == n_eff;
		stat.d_nonpos     = d_q <= 0;
		stat.den_zero     = den_q == '0;
		stat.step_small   = mag_q <= Q_W'(tol_q);
		stat.step_limit   = j_q >= JCNT_W'(NEWTON_LIMIT);
	end

	assign node_value   = x_q;
	assign weight_value = w_q;
	assign status       = st_q;
endmodule

// ===== hw/rtl/glnw_ctrl.sv =====
`timescale 1ns / 1ps
// Node/weight unit sequencer: one datapath op per cycle unless stalled.
// Depends on glnw_pkg.
module glnw_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  out_free,
	input  glnw_pkg::dp_status_t  stat,
	output glnw_pkg::ctrl_cmd_t   cmd
);
	import glnw_pkg::*;

	ctrl_state_t state_q, state_n;
	logic        weight_phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			weight_phase_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == ST_NEWTON_CHK)
				weight_phase_q <= 1'b0;
			else if (state_q == ST_WEIGHT_LEG)
				weight_phase_q <= 1'b1;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE:       if (in_valid) state_n = ST_SETUP;
			ST_SETUP: begin
				if (stat.out_of_range || stat.single)
					state_n = ST_DONE;
				else
					state_n = ST_THETA_WAIT;
			end
			ST_THETA_WAIT: if (stat.div_done) state_n = ST_CORDIC;
			ST_CORDIC:     if (stat.cordic_last) state_n = ST_CORDIC_END;
			ST_CORDIC_END: state_n = ST_NEWTON_D;
			ST_NEWTON_D:   state_n = ST_NEWTON_CHK;
			ST_NEWTON_CHK: state_n = stat.d_nonpos ? ST_WEIGHT_D : ST_LEG_MUL;
			ST_LEG_MUL:    state_n = ST_LEG_NUM;
			ST_LEG_NUM:    state_n = ST_LEG_WAIT;
			ST_LEG_WAIT: begin
				if (stat.div_done) begin
					if (!stat.leg_last)
						state_n = ST_LEG_MUL;
					else
						state_n = weight_phase_q ? ST_WEIGHT_Q : ST_NEWTON_A;
				end
			end
			ST_NEWTON_A:    state_n = ST_NEWTON_B;
			ST_NEWTON_B:    state_n = ST_NEWTON_DEN;
			ST_NEWTON_DEN:  state_n = ST_NEWTON_DIVS;
			ST_NEWTON_DIVS: state_n = stat.den_zero ? ST_WEIGHT_D : ST_NEWTON_WAIT;
			ST_NEWTON_WAIT: if (stat.div_done) state_n = ST_NEWTON_EVAL;
			ST_NEWTON_EVAL: begin
				if (stat.step_limit || stat.step_small)
					state_n = ST_WEIGHT_D;
				else
					state_n = ST_NEWTON_D;
			end
			ST_WEIGHT_D:     state_n = ST_WEIGHT_LEG;
			ST_WEIGHT_LEG:   state_n = ST_LEG_MUL;
			ST_WEIGHT_Q:     state_n = ST_WEIGHT_DIV1;
			ST_WEIGHT_DIV1:  state_n = ST_WEIGHT_WAIT1;
			ST_WEIGHT_WAIT1: if (stat.div_done) state_n = ST_WEIGHT_WAIT2;
			ST_WEIGHT_WAIT2: if (stat.div_done) state_n = ST_DONE;
			ST_DONE:         if (out_free) state_n = ST_IDLE;
			default:         state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op       = OP_NONE;
		cmd.out_load = 1'b0;
		in_ready     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_LOAD;
			end
			ST_SETUP: begin
				if (stat.out_of_range)
					cmd.op = OP_RANGE_ERR;
				else if (stat.single)
					cmd.op = OP_SINGLE;
				else
					cmd.op = OP_THETA;
			end
			ST_THETA_WAIT: if (stat.div_done) cmd.op = OP_CORDIC_INIT;
			ST_CORDIC:     cmd.op = OP_CORDIC_ITER;
			ST_CORDIC_END: cmd.op = OP_CORDIC_END;
			ST_NEWTON_D:   cmd.op = OP_NEWTON_D;
			ST_NEWTON_CHK: cmd.op = stat.d_nonpos ? OP_SET_LIMIT : OP_LEG_INIT;
			ST_LEG_MUL:    cmd.op = OP_LEG_MUL;
			ST_LEG_NUM:    cmd.op = OP_LEG_NUM;
			ST_LEG_WAIT:   if (stat.div_done) cmd.op = OP_LEG_UPDATE;
			ST_NEWTON_A:   cmd.op = OP_NEWTON_A;
			ST_NEWTON_B:   cmd.op = OP_NEWTON_B;
			ST_NEWTON_DEN: cmd.op = OP_NEWTON_DEN;
			ST_NEWTON_DIVS: cmd.op = stat.den_zero ? OP_SET_LIMIT : OP_NEWTON_DIV;
			ST_NEWTON_WAIT: if (stat.div_done) cmd.op = OP_NEWTON_STEP;
			ST_NEWTON_EVAL: begin
				if (stat.step_limit)
					cmd.op = OP_SET_LIMIT;
				else if (!stat.step_small)
					cmd.op = OP_NEWTON_UPDATE;
			end
			ST_WEIGHT_D:     cmd.op = OP_WEIGHT_D;
			ST_WEIGHT_LEG:   cmd.op = OP_LEG_INIT;
			ST_WEIGHT_Q:     cmd.op = OP_WEIGHT_Q;
			ST_WEIGHT_DIV1:  cmd.op = OP_WEIGHT_DIV1;
			ST_WEIGHT_WAIT1: if (stat.div_done) cmd.op = OP_WEIGHT_DIV2;
			ST_WEIGHT_WAIT2: if (stat.div_done) cmd.op = OP_WEIGHT_END;
			ST_DONE:         cmd.out_load = out_free;
			default: ;
		endcase
	end
endmodule

// ===== hw/rtl/gauss_legendre_node_weight_unit.sv =====
`timescale 1ns / 1ps
// Top level of the Gauss-Legendre node/weight unit.
// Depends on glnw_pkg, glnw_ctrl, glnw_datapath (which holds glnw_div).
//
// Usage:
//   Configuration: cfg_wen/cfg_index/cfg_data write point_count (index 0) or
//   newton_tolerance (index 1). Write only while the unit is idle.
//   Input channel: in_valid/in_ready with node_index; one transaction per node.
//   Output channel: out_valid/out_ready with node_value (Q2.30), weight_value
//   (Q2.30) and status; exactly one result transaction per input transaction.
// Operation: one node at a time; the next node is taken only after the last result
//   has gone to the output register. An out-of-range index or a single-point rule
//   goes from setup straight to its result. Otherwise: the start-angle division,
//   the CORDIC, then Newton evaluations (at most 51), each with a Legendre pass,
//   then the weight. The Legendre recurrence, whose division by k goes
//   through the shared 2-bit-per-cycle divider, takes most of the time.
// Stall: a finished result sits in the output register; the next node is taken
//   and worked on while it waits, and its result holds in the datapath until
//   the output register is free.
// Reset: asynchronous, active low; clears the sequencer and output valid and
//   restores point_count = 8, newton_tolerance = 1.
module gauss_legendre_node_weight_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [glnw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [glnw_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [glnw_pkg::IDX_W-1:0]        node_index,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [glnw_pkg::X_W-1:0]   node_value,
	output logic [glnw_pkg::W_W-1:0]          weight_value,
	output logic [glnw_pkg::ST_W-1:0]         status
);
	import glnw_pkg::*;

	dp_status_t          stat;
	ctrl_cmd_t           cmd;
	logic                out_free;
	logic signed [X_W-1:0] dp_node;
	logic [W_W-1:0]      dp_weight;
	logic [ST_W-1:0]     dp_status;

	logic                out_valid_q;
	logic signed [X_W-1:0] node_q;
	logic [W_W-1:0]      weight_q;
	logic [ST_W-1:0]     status_q;

	// Output register is free when empty or being drained this cycle.
	assign out_free = !out_valid_q || out_ready;

	glnw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_free (out_free),
		.stat     (stat),
		.cmd      (cmd)
	);

	glnw_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.node_index   (node_index),
		.op           (cmd.op),
		.stat         (stat),
		.node_value   (dp_node),
		.weight_value (dp_weight),
		.status       (dp_status)
	);

	// Hold valid until the transaction completes; load a new result on release.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			node_q   <= dp_node;
			weight_q <= dp_weight;
			status_q <= dp_status;
		end
	end

	assign out_valid    = out_valid_q;
	assign node_value   = node_q;
	assign weight_value = weight_q;
	assign status       = status_q;
endmodule
